// ===== design/assert_macros.svh =====
// Assertion macros for the RTL of the WAV header parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check that expr holds at every rising clock edge outside reset.
`define WAVHP_ASSERT_AT(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");

// Check that cons holds in the cycle after ante.
`define WAVHP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define WAVHP_ASSERT_AT(label, clk, rst_n, expr)
`define WAVHP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/wavhp_pkg.sv =====
// Types, codes and constants of the WAV header parser.
package wavhp_pkg;

	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	localparam logic [31:0] RATE_RESET     = 32'd22050;
	localparam logic [15:0] CHANNELS_RESET = 16'd1;
	localparam logic [15:0] BITS_RESET     = 16'd16;
	localparam logic [15:0] FORMAT_PCM     = 16'd1;
	localparam logic [31:0] FMT_MIN_SIZE   = 32'd16;

	localparam logic [2:0] PH_WAIT = 3'd0;
	localparam logic [2:0] PH_RIFF = 3'd1;
	localparam logic [2:0] PH_HDR  = 3'd2;
	localparam logic [2:0] PH_FMT  = 3'd3;
	localparam logic [2:0] PH_SKIP = 3'd4;

	localparam logic [2:0] STATUS_OK        = 3'd0;
	localparam logic [2:0] STATUS_NOT_RIFF  = 3'd1;
	localparam logic [2:0] STATUS_NOT_PCM   = 3'd2;
	localparam logic [2:0] STATUS_MISMATCH  = 3'd3;
	localparam logic [2:0] STATUS_NO_FMT    = 3'd4;
	localparam logic [2:0] STATUS_TRUNCATED = 3'd5;
	localparam logic [2:0] STATUS_SHORT_FMT = 3'd6;
	localparam logic [2:0] STATUS_OVERFLOW  = 3'd7;

	localparam logic [1:0] REG_RATE     = 2'd0;
	localparam logic [1:0] REG_CHANNELS = 2'd1;
	localparam logic [1:0] REG_BITS     = 2'd2;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       file_start;
		logic       file_end;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] data_offset;
		logic [31:0] pcm_bytes;
	} out_word_t;

	typedef struct packed {
		logic [31:0] rate;
		logic [15:0] channels;
		logic [15:0] bits;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  phase;
		logic [3:0]  field_index;
		logic [31:0] position;
		logic [31:0] skip_count;
		logic [31:0] tag_shift;
		logic [31:0] size_shift;
		logic [31:0] value_shift;
		logic        format_seen;
	} parse_state_t;

	function automatic logic [31:0] shift_in(input logic [31:0] acc, input logic [7:0] b);
		return {b, acc[31:8]};
	endfunction

endpackage

// ===== design/wavhp_parse.sv =====
// Next-state and result logic for one byte of the WAV header parser.
module wavhp_parse (
	input  wavhp_pkg::parse_state_t cur,
	input  wavhp_pkg::in_word_t     word,
	input  wavhp_pkg::cfg_t         cfg,
	output wavhp_pkg::parse_state_t nxt,
	output logic                    res_valid,
	output wavhp_pkg::out_word_t    res
);
	import wavhp_pkg::*;

	parse_state_t s;
	logic [31:0]  skip_dec;

	always_comb begin
		s = cur;
		skip_dec = '0;
		if (word.file_start) begin
			s = '0;
			s.phase = PH_RIFF;
		end
		nxt = s;
		res_valid = 1'b0;
		res = '0;
		res.status = STATUS_OK;
		if (s.phase != PH_WAIT) begin
			if (s.position == '1) begin
				res_valid = 1'b1;
				res.status = STATUS_OVERFLOW;
				nxt.phase = PH_WAIT;
			end else begin
				nxt.position = s.position + 32'd1;
				case (s.phase)
					PH_RIFF: begin
						if (s.field_index < 4'd4 || s.field_index >= 4'd8) begin
							nxt.tag_shift = shift_in(s.tag_shift, word.in_byte);
						end else begin
							nxt.size_shift = shift_in(s.size_shift, word.in_byte);
						end
						if (s.field_index == 4'd3 && nxt.tag_shift != TAG_RIFF) begin
							res_valid = 1'b1;
							res.status = STATUS_NOT_RIFF;
							nxt.phase = PH_WAIT;
						end else if (s.field_index == 4'd11) begin
							if (nxt.tag_shift != TAG_WAVE) begin
								res_valid = 1'b1;
								res.status = STATUS_NOT_RIFF;
								nxt.phase = PH_WAIT;
							end else begin
								nxt.phase = PH_HDR;
								nxt.field_index = '0;
							end
						end else begin
							nxt.field_index = s.field_index + 4'd1;
						end
					end
					PH_HDR: begin
						if (s.field_index < 4'd4) begin
							nxt.tag_shift = shift_in(s.tag_shift, word.in_byte);
						end else begin
							nxt.size_shift = shift_in(s.size_shift, word.in_byte);
						end
						if (s.field_index != 4'd7) begin
							nxt.field_index = s.field_index + 4'd1;
						end else if (nxt.tag_shift == TAG_DATA) begin
							res_valid = 1'b1;
							nxt.phase = PH_WAIT;
							if (s.format_seen) begin
								res.status = STATUS_OK;
								res.data_offset = nxt.position;
								res.pcm_bytes = nxt.size_shift;
							end else begin
								res.status = STATUS_NO_FMT;
							end
						end else if (nxt.tag_shift == TAG_FMT) begin
							if (nxt.size_shift < FMT_MIN_SIZE) begin
								res_valid = 1'b1;
								res.status = STATUS_SHORT_FMT;
								nxt.phase = PH_WAIT;
							end else begin
								nxt.skip_count = nxt.size_shift - FMT_MIN_SIZE;
								nxt.value_shift = '0;
								nxt.phase = PH_FMT;
								nxt.field_index = '0;
							end
						end else begin
							nxt.skip_count = nxt.size_shift;
							nxt.phase = (nxt.size_shift != '0) ? PH_SKIP : PH_HDR;
							nxt.field_index = '0;
						end
					end
					PH_FMT: begin
						nxt.value_shift = shift_in(s.value_shift, word.in_byte);
						if (s.field_index == 4'd1
							&& nxt.value_shift[31:16] != FORMAT_PCM) begin
							res_valid = 1'b1;
							res.status = STATUS_NOT_PCM;
							nxt.phase = PH_WAIT;
						end else if (s.field_index == 4'd3
							&& nxt.value_shift[31:16] != cfg.channels) begin
							res_valid = 1'b1;
							res.status = STATUS_MISMATCH;
							nxt.phase = PH_WAIT;
						end else if (s.field_index == 4'd7 && nxt.value_shift != cfg.rate) begin
							res_valid = 1'b1;
							res.status = STATUS_MISMATCH;
							nxt.phase = PH_WAIT;
						end else if (s.field_index == 4'd15) begin
							if (nxt.value_shift[31:16] != cfg.bits) begin
								res_valid = 1'b1;
								res.status = STATUS_MISMATCH;
								nxt.phase = PH_WAIT;
							end else begin
								nxt.format_seen = 1'b1;
								nxt.phase = (s.skip_count != '0) ? PH_SKIP : PH_HDR;
								nxt.field_index = '0;
							end
						end else begin
							nxt.field_index = s.field_index + 4'd1;
						end
					end
					PH_SKIP: begin
						skip_dec = (s.skip_count != '0) ? s.skip_count - 32'd1 : s.skip_count;
						nxt.skip_count = skip_dec;
						if (skip_dec == '0) begin
							nxt.phase = PH_HDR;
							nxt.field_index = '0;
						end
					end
					default: begin
						nxt.phase = PH_WAIT;
					end
				endcase
			end
			if (!res_valid && word.file_end && nxt.phase != PH_WAIT) begin
				res_valid = 1'b1;
				res = '0;
				res.status = STATUS_TRUNCATED;
				nxt.phase = PH_WAIT;
			end
		end
	end

endmodule

// ===== design/wavhp_out_buf.sv =====
// Two-entry result buffer: output register plus skid register.
module wavhp_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  wavhp_pkg::out_word_t push_word,
	output logic                 full,
	output logic                 out_valid,
	input  logic                 out_stall,
	output wavhp_pkg::out_word_t out_word
);
	import wavhp_pkg::*;

	logic      out_valid_q;
	logic      skid_valid_q;
	out_word_t out_q;
	out_word_t skid_q;
	logic      pop;

	assign pop = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= skid_valid_q;
			skid_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (!out_valid_q || pop) begin
				out_q <= push_word;
			end else begin
				skid_q <= push_word;
			end
		end else if (pop && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	assign full = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_word = out_q;

endmodule

// ===== design/wav_header_chunk_parser_core.sv =====
// Top level of the WAV header parser: config registers, parse state, result buffer.
// A result is pushed into the buffer as its byte is accepted; out_q or skid_q registers it.
// Throughput: one byte per cycle unless in_stall; state update is a single register stage.
// in_stall rises only when both result entries are held by a stalled output.
// Reset: async active low; parser waits for file start, config takes default values.
module wav_header_chunk_parser_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  wavhp_pkg::in_word_t  in_word,
	output logic                 out_valid,
	input  logic                 out_stall,
	output wavhp_pkg::out_word_t out_word,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data
);
	import wavhp_pkg::*;

	`include "assert_macros.svh"

	localparam logic [31:0] MIN_DATA_OFFSET = 32'd44;

	cfg_t         cfg_q;
	parse_state_t state_q;
	parse_state_t state_nxt;
	logic         res_valid;
	out_word_t    res;
	logic         accept;
	logic         buf_full;

	assign cfg_ready = 1'b1;
	assign accept = in_valid && !in_stall;
	assign in_stall = buf_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= {RATE_RESET, CHANNELS_RESET, BITS_RESET};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RATE:     cfg_q.rate <= cfg_data;
				REG_CHANNELS: cfg_q.channels <= cfg_data[15:0];
				REG_BITS:     cfg_q.bits <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	wavhp_parse u_parse (
		.cur       (state_q),
		.word      (in_word),
		.cfg       (cfg_q),
		.nxt       (state_nxt),
		.res_valid (res_valid),
		.res       (res)
	);

	wavhp_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && res_valid),
		.push_word (res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

	`WAVHP_ASSERT_AT(a_skid_behind_out, clk, arst_n, !in_stall || out_valid)
	`WAVHP_ASSERT_AT(a_ok_offset, clk, arst_n,
		!(out_valid && out_word.status == STATUS_OK) || out_word.data_offset >= MIN_DATA_OFFSET)
	`WAVHP_ASSERT_NEXT(a_wait_holds, clk, arst_n,
		accept && state_q.phase == PH_WAIT && !in_word.file_start, state_q.phase == PH_WAIT)

endmodule

// ===== tb/wav_header_chunk_parser_core_tb.sv =====
// Self-checking testbench for the WAV header and chunk parser core.
module wav_header_chunk_parser_core_tb;
	import wavhp_pkg::*;

	localparam int CYCLE_LIMIT = 100000;

	typedef enum int {
		FK_GOOD, FK_NO_FMT, FK_SHORT_FMT, FK_NOT_PCM, FK_BAD_CHAN, FK_BAD_RATE,
		FK_BAD_BITS, FK_MUTATE, FK_TRUNC, FK_RESTART, FK_JUNK
	} file_kind_t;

	class header_status_board;
		logic [31:0] exp_rate;
		logic [15:0] exp_chan;
		logic [15:0] exp_bits;
		logic [2:0]  ph;
		int unsigned fidx;
		logic [31:0] pos;
		logic [31:0] skip_left;
		logic [31:0] tag_acc;
		logic [31:0] size_acc;
		logic [31:0] val_acc;
		bit          fmt_ok;
		out_word_t   status_due[$];
		int unsigned errors;
		int unsigned parsed;
		int unsigned made;
		int unsigned seen;
		int unsigned tally[8];

		function new();
			exp_rate = RATE_RESET;
			exp_chan = CHANNELS_RESET;
			exp_bits = BITS_RESET;
			ph = PH_WAIT;
			fidx = 0;
			pos = '0;
			skip_left = '0;
			tag_acc = '0;
			size_acc = '0;
			val_acc = '0;
			fmt_ok = 1'b0;
			errors = 0;
			parsed = 0;
			made = 0;
			seen = 0;
			foreach (tally[i]) tally[i] = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] v);
			case (idx)
			REG_RATE: exp_rate = v;
			REG_CHANNELS: exp_chan = v[15:0];
			REG_BITS: exp_bits = v[15:0];
			default: ;
			endcase
		endfunction

		function bit conclude(logic [2:0] st, logic [31:0] off, logic [31:0] sz);
			out_word_t w;
			w.status = st;
			w.data_offset = off;
			w.pcm_bytes = sz;
			status_due.push_back(w);
			made++;
			ph = PH_WAIT;
			return 1'b1;
		endfunction

		function void enter_chunk();
			ph = (skip_left != 0) ? PH_SKIP : PH_HDR;
			fidx = 0;
		endfunction

		function bit parse_byte(logic [7:0] b);
			int unsigned idx;
			idx = fidx;
			if (pos == 32'hFFFF_FFFF) return conclude(STATUS_OVERFLOW, '0, '0);
			pos++;
			case (ph)
			PH_RIFF: begin
				if (idx < 4 || idx >= 8) tag_acc = {b, tag_acc[31:8]};
				else size_acc = {b, size_acc[31:8]};
				if (idx == 3 && tag_acc != TAG_RIFF) return conclude(STATUS_NOT_RIFF, '0, '0);
				if (idx == 11) begin
					if (tag_acc != TAG_WAVE) return conclude(STATUS_NOT_RIFF, '0, '0);
					ph = PH_HDR;
					fidx = 0;
				end else begin
					fidx = idx + 1;
				end
				return 1'b0;
			end
			PH_HDR: begin
				if (idx < 4) tag_acc = {b, tag_acc[31:8]};
				else size_acc = {b, size_acc[31:8]};
				if (idx != 7) begin
					fidx = idx + 1;
					return 1'b0;
				end
				if (tag_acc == TAG_DATA) begin
					if (fmt_ok) return conclude(STATUS_OK, pos, size_acc);
					return conclude(STATUS_NO_FMT, '0, '0);
				end
				if (tag_acc == TAG_FMT) begin
					if (size_acc < FMT_MIN_SIZE) return conclude(STATUS_SHORT_FMT, '0, '0);
					skip_left = size_acc - FMT_MIN_SIZE;
					val_acc = '0;
					ph = PH_FMT;
					fidx = 0;
					return 1'b0;
				end
				skip_left = size_acc;
				enter_chunk();
				return 1'b0;
			end
			PH_FMT: begin
				val_acc = {b, val_acc[31:8]};
				if (idx == 1 && val_acc[31:16] != FORMAT_PCM)
					return conclude(STATUS_NOT_PCM, '0, '0);
				if (idx == 3 && val_acc[31:16] != exp_chan)
					return conclude(STATUS_MISMATCH, '0, '0);
				if (idx == 7 && val_acc != exp_rate) return conclude(STATUS_MISMATCH, '0, '0);
				if (idx == 15) begin
					if (val_acc[31:16] != exp_bits) return conclude(STATUS_MISMATCH, '0, '0);
					fmt_ok = 1'b1;
					enter_chunk();
				end else begin
					fidx = idx + 1;
				end
				return 1'b0;
			end
			PH_SKIP: begin
				if (skip_left != 0) skip_left--;
				if (skip_left == 0) begin
					ph = PH_HDR;
					fidx = 0;
				end
				return 1'b0;
			end
			default: begin
				ph = PH_WAIT;
				return 1'b0;
			end
			endcase
		endfunction

		function void note_byte(in_word_t w);
			bit got;
			if (w.file_start) begin
				ph = PH_RIFF;
				fidx = 0;
				pos = '0;
				skip_left = '0;
				tag_acc = '0;
				size_acc = '0;
				val_acc = '0;
				fmt_ok = 1'b0;
			end
			if (ph == PH_WAIT) return;
			parsed++;
			got = parse_byte(w.in_byte);
			if (!got && w.file_end && ph != PH_WAIT) got = conclude(STATUS_TRUNCATED, '0, '0);
		endfunction

		function void check_status(out_word_t got);
			out_word_t want;
			seen++;
			if (status_due.size() == 0) begin
				$display("%0t: unexpected word status %0d offset %0h size %0h", $time,
					got.status, got.data_offset, got.pcm_bytes);
				errors++;
				return;
			end
			want = status_due.pop_front();
			tally[want.status]++;
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
				errors++;
			end
			if (got.data_offset !== want.data_offset) begin
				$display("%0t: data_offset expected %0h actual %0h", $time,
					want.data_offset, got.data_offset);
				errors++;
			end
			if (got.pcm_bytes !== want.pcm_bytes) begin
				$display("%0t: pcm_bytes expected %0h actual %0h", $time,
					want.pcm_bytes, got.pcm_bytes);
				errors++;
			end
		endfunction

		function int pending();
			return status_due.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_word_t    in_word;
	logic        out_valid;
	logic        out_stall;
	out_word_t   out_word;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	header_status_board board;
	in_word_t file_q[$];
	bit tx_calm;
	bit rx_calm;
	bit hold_req;
	int unsigned cycles;

	wav_header_chunk_parser_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) board.check_status(out_word);
	end

	// hold off per word; one long hold on request
	initial begin : receiver
		int wait_n;
		int unsigned taken;
		taken = 0;
		rx_calm = 1'b0;
		out_stall <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				wait_n = 90;
				hold_req = 1'b0;
			end else begin
				wait_n = rx_calm ? 0 : $urandom_range(0, 13);
			end
			if (wait_n != 0) begin
				out_stall <= 1'b1;
				repeat (wait_n) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			taken++;
			if (taken % 8 == 0) rx_calm = ($urandom_range(0, 3) == 0);
		end
	end

	function automatic in_word_t mk_word(logic [7:0] b, logic s, logic e);
		in_word_t w;
		w.in_byte = b;
		w.file_start = s;
		w.file_end = e;
		return w;
	endfunction

	function automatic void put8(logic [7:0] b);
		file_q.push_back(mk_word(b, 1'b0, 1'b0));
	endfunction

	function automatic void put16(logic [15:0] v);
		put8(v[7:0]);
		put8(v[15:8]);
	endfunction

	function automatic void put32(logic [31:0] v);
		put16(v[15:0]);
		put16(v[31:16]);
	endfunction

	function automatic void put_other_chunk();
		logic [31:0] id;
		int unsigned sz;
		id = $urandom;
		if (id == TAG_FMT || id == TAG_DATA) id ^= 32'h1;
		sz = $urandom_range(0, 5);
		put32(id);
		put32(sz);
		repeat (sz) put8(8'($urandom));
	endfunction

	function automatic file_kind_t pick_kind();
		int r;
		r = $urandom_range(0, 13);
		if (r <= 3) return FK_GOOD;
		return file_kind_t'(r - 3);
	endfunction

	function automatic void build_file(input file_kind_t kind);
		int k;
		int ext;
		int reps;
		logic [31:0] fsize;
		file_q.delete();
		if (kind == FK_JUNK) begin
			repeat ($urandom_range(1, 8))
				file_q.push_back(mk_word(8'($urandom), $urandom_range(0, 3) == 0,
					$urandom_range(0, 3) == 0));
			return;
		end
		put32(TAG_RIFF);
		put32($urandom);
		put32(TAG_WAVE);
		repeat ($urandom_range(0, 2)) put_other_chunk();
		reps = (kind == FK_NO_FMT) ? 0 : ($urandom_range(0, 4) == 0) ? 2 : 1;
		repeat (reps) begin
			ext = $urandom_range(0, 1) ? 0 : $urandom_range(1, 4);
			fsize = (kind == FK_SHORT_FMT) ? $urandom_range(0, 15) : 16 + ext;
			put32(TAG_FMT);
			put32(fsize);
			put16(kind == FK_NOT_PCM ? FORMAT_PCM ^ 16'($urandom_range(1, 65535)) : FORMAT_PCM);
			put16(board.exp_chan ^ (kind == FK_BAD_CHAN ? 16'($urandom_range(1, 65535)) : 16'd0));
			put32(board.exp_rate ^ (kind == FK_BAD_RATE ? $urandom_range(1, 32'hFFFF_FFFF) : 32'd0));
			put32($urandom);
			put16(16'($urandom));
			put16(board.exp_bits ^ (kind == FK_BAD_BITS ? 16'($urandom_range(1, 65535)) : 16'd0));
			repeat (ext) put8(8'($urandom));
			if ($urandom_range(0, 2) == 0) put_other_chunk();
		end
		put32(TAG_DATA);
		put32($urandom);
		repeat ($urandom_range(0, 2)) put8(8'($urandom));
		file_q[0].file_start = 1'b1;
		k = $urandom_range(0, file_q.size() - 2);
		case (kind)
		FK_MUTATE: file_q[k].in_byte = 8'($urandom);
		FK_TRUNC, FK_RESTART: while (file_q.size() > k + 1) void'(file_q.pop_back());
		default: ;
		endcase
		if (kind != FK_RESTART) file_q[file_q.size() - 1].file_end = 1'b1;
	endfunction

	task automatic send_word(input in_word_t w);
		int gap;
		in_valid <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_byte(w);
		gap = tx_calm ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_file();
		foreach (file_q[i]) send_word(file_q[i]);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_beat(input logic [1:0] idx, input logic [31:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.set_reg(idx, val);
	endtask

	task automatic load_format(input logic [31:0] rate, input logic [15:0] chans,
			input logic [15:0] bits);
		cfg_valid <= 1'b1;
		cfg_beat(REG_RATE, rate);
		cfg_beat(REG_CHANNELS, {16'd0, chans});
		cfg_beat(REG_BITS, {16'd0, bits});
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int unsigned goal_bytes;
		int unsigned goal_words;
		board = new();
		cycles = 0;
		tx_calm = 1'b0;
		hold_req = 1'b0;
		arst_n = 1'b0;
		in_valid <= 1'b0;
		in_word <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_RATE;
		cfg_data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(mk_word(8'h00, 1'b0, 1'b0));
		send_word(mk_word(8'hFF, 1'b0, 1'b1));
		send_word(mk_word(8'hA5, 1'b1, 1'b1));
		file_q.delete();
		put32(TAG_RIFF ^ 32'h1E00_0000);
		file_q[0].file_start = 1'b1;
		send_file();
		file_q.delete();
		put32(TAG_RIFF);
		put32('1);
		put32(TAG_WAVE ^ 32'h3100_0000);
		file_q[0].file_start = 1'b1;
		send_file();
		send_word(mk_word(8'h52, 1'b1, 1'b0));
		send_word(mk_word(8'h49, 1'b0, 1'b0));
		send_word(mk_word(8'h52, 1'b1, 1'b1));

		for (int p = 0; p < 5; p++) begin
			drain();
			case (p)
			1: load_format(32'd44100, 16'd2, 16'd16);
			2: load_format('0, '0, '0);
			3: load_format('1, '1, '1);
			4: load_format($urandom, 16'($urandom), 16'($urandom));
			default: ;
			endcase
			goal_bytes = board.parsed + 40;
			goal_words = board.made + 1;
			if (p == 1) begin
				// fill the result buffer while the receiver holds off
				hold_req = 1'b1;
				tx_calm = 1'b1;
				repeat (24) send_word(mk_word(8'($urandom), 1'b1, 1'b1));
			end
			while (board.parsed < goal_bytes || board.made < goal_words) begin
				tx_calm = ($urandom_range(0, 3) == 0);
				build_file(pick_kind());
				send_file();
			end
			build_file(FK_GOOD);
			send_file();
		end
		drain();

		$display("covered %0d parsed bytes and %0d status words over five format settings",
			board.parsed, board.seen);
		$display("ok %0d, not riff %0d, not pcm %0d, mismatch %0d",
			board.tally[STATUS_OK], board.tally[STATUS_NOT_RIFF], board.tally[STATUS_NOT_PCM],
			board.tally[STATUS_MISMATCH]);
		$display("no fmt %0d, truncated %0d, short fmt %0d",
			board.tally[STATUS_NO_FMT], board.tally[STATUS_TRUNCATED],
			board.tally[STATUS_SHORT_FMT]);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
